// ===== design/spt_pkg.sv =====
`default_nettype none
package spt_pkg;

   localparam int CHANNELS  = 4;
   localparam int FRAC_BITS = 16;
   localparam int ANG_W     = 24;
   localparam int PULSE_W   = 15;
   localparam int ZONE_W    = 8;
   localparam int SPEED_W   = 8;
   localparam int NUM_W     = 27;
   localparam int DVD_W     = 44;
   localparam int DVS_W     = 36;
   localparam int ACC_W     = 44;
   localparam int CNT_W     = $clog2(DVD_W + 1);
   localparam int RECIP_W     = 25;
   localparam int RECIP_SHIFT = 32;

   localparam logic [ANG_W-1:0] ONE_DEG    = ANG_W'(1 << FRAC_BITS);
   localparam logic [ANG_W-1:0] FULL_DEG   = ANG_W'(180 << FRAC_BITS);
   localparam logic [ANG_W-1:0] CENTER_DEG = ANG_W'(90 << FRAC_BITS);

   // ceil(2^32 / 180), exact for dividends below 2^24
   localparam logic [RECIP_W-1:0] RECIP_180 = 25'd23860930;

   localparam logic [2:0] ACT_TICK    = 3'd0;
   localparam logic [2:0] ACT_MOVE    = 3'd1;
   localparam logic [2:0] ACT_SET     = 3'd2;
   localparam logic [2:0] ACT_SPEED   = 3'd3;
   localparam logic [2:0] ACT_DISABLE = 3'd4;

   localparam logic [1:0] CSR_PULSE_MIN = 2'd0;
   localparam logic [1:0] CSR_PULSE_MAX = 2'd1;
   localparam logic [1:0] CSR_ACCEL     = 2'd2;
   localparam logic [1:0] CSR_DEF_SPEED = 2'd3;

   localparam logic [PULSE_W-1:0] RST_PULSE_MIN = 15'd500;
   localparam logic [PULSE_W-1:0] RST_PULSE_MAX = 15'd2400;
   localparam logic [ZONE_W-1:0]  RST_ACCEL     = 8'd10;
   localparam logic [SPEED_W-1:0] RST_SPEED     = 8'd10;

   typedef struct packed {
      logic [2:0]         action;
      logic [1:0]         channel;
      logic [ANG_W-1:0]   angle;
      logic [SPEED_W-1:0] speed;
   } req_type;

   typedef struct packed {
      logic [1:0]         out_channel;
      logic [PULSE_W-1:0] compare_us;
      logic [ANG_W-1:0]   position;
      logic               in_motion;
      logic               pwm_enabled;
      logic               last;
   } rsp_type;

endpackage
`default_nettype wire

// ===== design/spt_divider.sv =====
`default_nettype none
module spt_divider (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [spt_pkg::DVD_W-1:0]  dividend,
   input  wire logic [spt_pkg::DVS_W-1:0]  divisor,
   output logic                            done,
   output logic [spt_pkg::DVD_W-1:0]       quotient
);
   import spt_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[DVD_W-1]};
      fits    = trial >= {1'b0, dvs_ff};
      diff    = trial - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_W);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ===== design/servo_trapezoid_profiler.sv =====
`default_nettype none
// Four-channel servo motion profiler. A request is taken when start is high and busy
// is low; results appear one per cycle of rsp_strobe and cannot be stalled, so the
// receiver must take every strobe. The step size runs through one bit-serial divider;
// the pulse width uses a reciprocal multiply. A move, set or speed request keeps busy
// high through states CMD and PM1 to PM4, a disable through SEL and PM1 to PM4 for each
// channel, and a tick through SEL per idle channel, SEL, T1 and PM1 to PM4 per channel
// that snaps to its goal, and SEL, T1 to T4, TDIV and PM1 to PM4 per channel that steps.
module servo_trapezoid_profiler (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire spt_pkg::req_type                   req_payload,
   output logic                                    rsp_strobe,
   output spt_pkg::rsp_type                        rsp_payload,
   input  wire logic                               csr_we,
   input  wire logic [1:0]                         csr_index,
   input  wire logic [spt_pkg::PULSE_W-1:0]        csr_wdata
);
   import spt_pkg::*;

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PQ_W = ANG_W + RECIP_W;

   typedef enum logic [11:0] {
      ST_IDLE = 12'b000000000001,
      ST_CMD  = 12'b000000000010,
      ST_SEL  = 12'b000000000100,
      ST_T1   = 12'b000000001000,
      ST_T2   = 12'b000000010000,
      ST_T3   = 12'b000000100000,
      ST_T4   = 12'b000001000000,
      ST_TDIV = 12'b000010000000,
      ST_PM1  = 12'b000100000000,
      ST_PM2  = 12'b001000000000,
      ST_PM3  = 12'b010000000000,
      ST_PM4  = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   logic [CH_W-1:0] idx_ff, idx_in;

   logic [PULSE_W-1:0] pmin_ff, pmin_in, pmax_ff, pmax_in;
   logic [ZONE_W-1:0]  accel_ff, accel_in;
   logic [SPEED_W-1:0] dspd_ff, dspd_in;

   logic [ANG_W-1:0]   now_ff [CHANNELS];
   logic [ANG_W-1:0]   now_in [CHANNELS];
   logic [ANG_W-1:0]   goal_ff [CHANNELS];
   logic [ANG_W-1:0]   goal_in [CHANNELS];
   logic [ANG_W-1:0]   trav_ff [CHANNELS];
   logic [ANG_W-1:0]   trav_in [CHANNELS];
   logic [SPEED_W-1:0] mspd_ff [CHANNELS];
   logic [SPEED_W-1:0] mspd_in [CHANNELS];
   logic [CHANNELS-1:0] moving_ff, moving_in;
   logic               on_ff, on_in;

   logic [ANG_W-1:0]   rem_ff, rem_in, total_ff, total_in;
   logic [ANG_W-1:0]   zone_ff, zone_in, dist_ff, dist_in;
   logic [NUM_W-1:0]   num_ff, num_in, z5_ff, z5_in;
   logic [SPEED_W-1:0] spd_ff, spd_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [ANG_W-1:0]   px_ff, px_in;

   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_ff, rsp_in;

   logic               div_start, div_done;
   logic [DVD_W-1:0]   div_dividend, div_quotient;
   logic [DVS_W-1:0]   div_divisor;

   logic [ANG_W-1:0]   cur_now, cur_goal, zone0, diff, step24;
   logic [DVD_W-1:0]   step;
   logic               ramp_ok, any_above;
   logic signed [ACC_W-1:0] a_s, d_s, pnum;
   logic [PQ_W-1:0]    pq;

   spt_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      idx_in   = idx_ff;
      pmin_in  = pmin_ff;
      pmax_in  = pmax_ff;
      accel_in = accel_ff;
      dspd_in  = dspd_ff;
      now_in   = now_ff;
      goal_in  = goal_ff;
      trav_in  = trav_ff;
      mspd_in  = mspd_ff;
      moving_in = moving_ff;
      on_in    = on_ff;
      rem_in   = rem_ff;
      total_in = total_ff;
      zone_in  = zone_ff;
      dist_in  = dist_ff;
      num_in   = num_ff;
      z5_in    = z5_ff;
      spd_in   = spd_ff;
      acc_in   = acc_ff;
      px_in    = px_ff;
      rsp_strobe_in = 1'b0;
      rsp_in   = rsp_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;

      cur_now  = now_ff[idx_ff];
      cur_goal = goal_ff[idx_ff];
      zone0    = ANG_W'({accel_ff, 16'b0} >> (16 - FRAC_BITS));
      ramp_ok  = (28'(zone_ff) * 28'd10) > 28'(ONE_DEG);
      step     = (div_quotient == '0) ? DVD_W'(1) : div_quotient;
      step24   = ANG_W'(step);
      diff     = (cur_goal > cur_now) ? cur_goal - cur_now : cur_now - cur_goal;
      a_s      = ACC_W'($signed({1'b0, cur_now}));
      d_s      = ACC_W'($signed({1'b0, pmax_ff})) - ACC_W'($signed({1'b0, pmin_ff}));
      pnum     = (acc_ff <<< 1) + ACC_W'($signed({1'b0, FULL_DEG}));
      pq       = PQ_W'(px_ff) * PQ_W'(RECIP_180);
      any_above = 1'b0;
      for (int j = 0; j < CHANNELS; j++) begin
         if (CH_W'(j) > idx_ff && moving_ff[j]) begin
            any_above = 1'b1;
         end
      end

      if (csr_we) begin
         unique case (csr_index)
            CSR_PULSE_MIN: pmin_in  = csr_wdata;
            CSR_PULSE_MAX: pmax_in  = csr_wdata;
            CSR_ACCEL:     accel_in = csr_wdata[ZONE_W-1:0];
            CSR_DEF_SPEED: dspd_in  = csr_wdata[SPEED_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_payload;
               if (req_payload.angle > FULL_DEG) begin
                  req_in.angle = FULL_DEG;
               end
               idx_in = '0;
               if (req_payload.action == ACT_TICK) begin
                  state_in = ST_SEL;
               end else if (req_payload.action == ACT_DISABLE) begin
                  on_in     = 1'b0;
                  moving_in = '0;
                  state_in  = ST_SEL;
               end else if ((req_payload.action == ACT_MOVE ||
                             req_payload.action == ACT_SET ||
                             req_payload.action == ACT_SPEED) &&
                            32'(req_payload.channel) < CHANNELS) begin
                  idx_in   = CH_W'(req_payload.channel);
                  state_in = ST_CMD;
               end
            end
         end
         ST_CMD: begin
            priority if (req_ff.action == ACT_MOVE) begin
               trav_in[idx_ff] = (req_ff.angle > cur_now) ? req_ff.angle - cur_now
                                                          : cur_now - req_ff.angle;
               goal_in[idx_ff] = req_ff.angle;
               mspd_in[idx_ff] = (req_ff.speed == '0) ? dspd_ff : req_ff.speed;
               moving_in[idx_ff] = 1'b1;
            end else if (req_ff.action == ACT_SET) begin
               now_in[idx_ff]    = req_ff.angle;
               goal_in[idx_ff]   = req_ff.angle;
               moving_in[idx_ff] = 1'b0;
            end else begin
               mspd_in[idx_ff] = (req_ff.speed == '0) ? SPEED_W'(1) : req_ff.speed;
            end
            state_in = ST_PM1;
         end
         ST_SEL: begin
            if (req_ff.action == ACT_TICK && !moving_ff[idx_ff]) begin
               if (idx_ff == CH_W'(CHANNELS - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else if (req_ff.action == ACT_TICK) begin
               state_in = ST_T1;
            end else begin
               state_in = ST_PM1;
            end
         end
         ST_T1: begin
            rem_in = diff;
            if (27'(diff) * 27'd5 < 27'(ONE_DEG)) begin
               now_in[idx_ff]    = cur_goal;
               moving_in[idx_ff] = 1'b0;
               state_in = ST_PM1;
            end else begin
               total_in = (trav_ff[idx_ff] < ONE_DEG) ? ONE_DEG : trav_ff[idx_ff];
               spd_in   = (mspd_ff[idx_ff] == '0) ? SPEED_W'(1) : mspd_ff[idx_ff];
               state_in = ST_T2;
            end
         end
         ST_T2: begin
            zone_in  = ({1'b0, zone0} << 1 > {1'b0, total_ff}) ? total_ff >> 1 : zone0;
            dist_in  = (rem_ff > total_ff) ? '0 : total_ff - rem_ff;
            state_in = ST_T3;
         end
         ST_T3: begin
            if (ramp_ok && dist_ff < zone_ff) begin
               num_in = NUM_W'(zone_ff) + (NUM_W'(dist_ff) << 2);
            end else if (ramp_ok && rem_ff < zone_ff) begin
               num_in = NUM_W'(zone_ff) + (NUM_W'(rem_ff) << 2);
            end else begin
               num_in = '0;
            end
            z5_in    = NUM_W'(zone_ff) * NUM_W'(5);
            state_in = ST_T4;
         end
         ST_T4: begin
            div_start = 1'b1;
            if (num_ff != '0) begin
               div_dividend = DVD_W'(num_ff) << FRAC_BITS;
               div_divisor  = DVS_W'(z5_ff) * DVS_W'(spd_ff);
            end else begin
               div_dividend = DVD_W'(ONE_DEG);
               div_divisor  = DVS_W'(spd_ff);
            end
            state_in = ST_TDIV;
         end
         ST_TDIV: begin
            if (div_done) begin
               if (DVD_W'(diff) > step) begin
                  now_in[idx_ff] = (cur_goal > cur_now) ? cur_now + step24
                                                        : cur_now - step24;
               end else begin
                  now_in[idx_ff] = cur_goal;
               end
               state_in = ST_PM1;
            end
         end
         ST_PM1: begin
            acc_in   = ACC_W'(pmin_ff) * ACC_W'(FULL_DEG);
            state_in = ST_PM2;
         end
         ST_PM2: begin
            acc_in   = acc_ff + a_s * d_s;
            state_in = ST_PM3;
         end
         ST_PM3: begin
            // divide by 2*180*2^F: shift out 2^(F+1), then divide by 180
            px_in    = pnum[ACC_W-1] ? '0 : ANG_W'(pnum >> (FRAC_BITS + 1));
            state_in = ST_PM4;
         end
         ST_PM4: begin
            rsp_strobe_in        = 1'b1;
            rsp_in.out_channel   = 2'(idx_ff);
            rsp_in.compare_us    = pq[RECIP_SHIFT +: PULSE_W];
            rsp_in.position      = cur_now;
            rsp_in.in_motion     = moving_ff[idx_ff];
            rsp_in.pwm_enabled   = on_ff;
            if (req_ff.action == ACT_TICK) begin
               rsp_in.last = !any_above;
            end else if (req_ff.action == ACT_DISABLE) begin
               rsp_in.last = (idx_ff == CH_W'(CHANNELS - 1));
            end else begin
               rsp_in.last = 1'b1;
            end
            if (req_ff.action != ACT_TICK && req_ff.action != ACT_DISABLE) begin
               state_in = ST_IDLE;
            end else if (idx_ff == CH_W'(CHANNELS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SEL;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pmin_ff  <= RST_PULSE_MIN;
         pmax_ff  <= RST_PULSE_MAX;
         accel_ff <= RST_ACCEL;
         dspd_ff  <= RST_SPEED;
         for (int i = 0; i < CHANNELS; i++) begin
            now_ff[i]  <= CENTER_DEG;
            goal_ff[i] <= CENTER_DEG;
            trav_ff[i] <= '0;
            mspd_ff[i] <= RST_SPEED;
         end
         moving_ff     <= '0;
         on_ff         <= 1'b1;
         rsp_strobe_ff <= 1'b0;
         idx_ff        <= '0;
      end else begin
         state_ff <= state_in;
         pmin_ff  <= pmin_in;
         pmax_ff  <= pmax_in;
         accel_ff <= accel_in;
         dspd_ff  <= dspd_in;
         now_ff   <= now_in;
         goal_ff  <= goal_in;
         trav_ff  <= trav_in;
         mspd_ff  <= mspd_in;
         moving_ff     <= moving_in;
         on_ff         <= on_in;
         rsp_strobe_ff <= rsp_strobe_in;
         idx_ff        <= idx_in;
      end
      req_ff   <= req_in;
      rem_ff   <= rem_in;
      total_ff <= total_in;
      zone_ff  <= zone_in;
      dist_ff  <= dist_in;
      num_ff   <= num_in;
      z5_ff    <= z5_in;
      spd_ff   <= spd_in;
      acc_ff   <= acc_in;
      px_ff    <= px_in;
      rsp_ff   <= rsp_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

// ===== dv/servo_trapezoid_profiler_test.sv =====
`default_nettype none
module servo_trapezoid_profiler_test;
   import spt_pkg::*;

   localparam int NCH = 4;
   localparam logic [2:0] ACT_UNUSED = 3'd5;
   localparam int QUIET_LIMIT = 6000;
   localparam int SETTLE_CYCLES = 500;
   localparam longint unsigned UNIT = 64'd1 << FRAC_BITS;
   localparam longint unsigned FULL = 64'd180 << FRAC_BITS;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_payload = '0;
   logic rsp_strobe;
   rsp_type rsp_payload;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = CSR_PULSE_MIN;
   logic [PULSE_W-1:0] csr_wdata = '0;

   servo_trapezoid_profiler dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // servo profile state
   longint unsigned pos_now[NCH], pos_goal[NCH], span[NCH];
   int unsigned rate[NCH];
   bit moving[NCH];
   bit pwm_on;
   int unsigned pw_min, pw_max, zone_deg, speed_dflt;

   rsp_type expected_reports[$];
   int errors = 0;
   int quiet = 0;
   bit gaps_on = 1'b1;

   function automatic longint unsigned servo_pulse(longint unsigned a);
      longint lo, d, den, num;
      lo = longint'(pw_min);
      d = longint'(pw_max) - lo;
      den = longint'(FULL);
      num = 2 * (lo * den + longint'(a) * d) + den;
      if (num < 0) num = 0;
      return longint'(num / (2 * den));
   endfunction

   function automatic void report_channel(int ch);
      rsp_type r;
      r.out_channel = ch[1:0];
      r.compare_us = PULSE_W'(servo_pulse(pos_now[ch]));
      r.position = ANG_W'(pos_now[ch]);
      r.in_motion = moving[ch];
      r.pwm_enabled = pwm_on;
      r.last = 1'b0;
      expected_reports.push_back(r);
   endfunction

   function automatic void advance_channel(int ch);
      longint unsigned now, goal, rem, total, zone, covered, spd, step, num;
      bit ramp;
      now = pos_now[ch];
      goal = pos_goal[ch];
      rem = goal > now ? goal - now : now - goal;
      if (5 * rem < UNIT) begin
         pos_now[ch] = goal;
         moving[ch] = 1'b0;
         return;
      end
      total = span[ch] < UNIT ? UNIT : span[ch];
      zone = longint'(zone_deg) << FRAC_BITS;
      if (2 * zone > total) zone = total >> 1;
      covered = rem > total ? 0 : total - rem;
      spd = rate[ch] == 0 ? 1 : rate[ch];
      ramp = 10 * zone > UNIT;
      if (ramp && covered < zone) num = zone + 4 * covered;
      else if (ramp && rem < zone) num = zone + 4 * rem;
      else num = 0;
      if (num != 0) step = (UNIT * num) / (5 * zone * spd);
      else step = UNIT / spd;
      if (step == 0) step = 1;
      if (goal > now) now = (goal - now > step) ? now + step : goal;
      else now = (now - goal > step) ? now - step : goal;
      pos_now[ch] = now;
   endfunction

   function automatic void predict_command(req_type rq);
      longint unsigned ang;
      int first_new, ch;
      first_new = expected_reports.size();
      ang = rq.angle > FULL ? FULL : rq.angle;
      ch = rq.channel;
      case (rq.action)
         ACT_TICK: begin
            for (int i = 0; i < NCH; i++) begin
               if (moving[i]) begin
                  advance_channel(i);
                  report_channel(i);
               end
            end
         end
         ACT_DISABLE: begin
            pwm_on = 1'b0;
            for (int i = 0; i < NCH; i++) moving[i] = 1'b0;
            for (int i = 0; i < NCH; i++) report_channel(i);
         end
         ACT_MOVE: begin
            span[ch] = ang > pos_now[ch] ? ang - pos_now[ch] : pos_now[ch] - ang;
            pos_goal[ch] = ang;
            rate[ch] = rq.speed == 0 ? speed_dflt : rq.speed;
            moving[ch] = 1'b1;
            report_channel(ch);
         end
         ACT_SET: begin
            pos_now[ch] = ang;
            pos_goal[ch] = ang;
            moving[ch] = 1'b0;
            report_channel(ch);
         end
         ACT_SPEED: begin
            rate[ch] = rq.speed == 0 ? 1 : rq.speed;
            report_channel(ch);
         end
         default: ;
      endcase
      if (expected_reports.size() > first_new)
         expected_reports[expected_reports.size() - 1].last = 1'b1;
   endfunction

   function automatic bit any_moving();
      for (int i = 0; i < NCH; i++) if (moving[i]) return 1'b1;
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      if (!reset && ((start && !busy) || rsp_strobe)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_reports.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %p", rsp_payload);
         end else begin
            rsp_type e;
            e = expected_reports.pop_front();
            if (rsp_payload !== e) begin
               errors++;
               if (errors <= 10) $display("mismatch: expected %p got %p", e, rsp_payload);
            end
         end
      end
   end

   task automatic send(logic [2:0] act, logic [1:0] ch, logic [ANG_W-1:0] ang,
                       logic [SPEED_W-1:0] spd);
      req_type rq;
      int n;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 15);
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
      rq.action = act;
      rq.channel = ch;
      rq.angle = ang;
      rq.speed = spd;
      start <= 1'b1;
      req_payload <= rq;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_command(rq);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [PULSE_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_PULSE_MIN: pw_min = val;
         CSR_PULSE_MAX: pw_max = val;
         CSR_ACCEL: zone_deg = val[7:0];
         CSR_DEF_SPEED: speed_dflt = val[7:0];
         default: ;
      endcase
   endtask

   task automatic set_profile(int pmin, int pmax, int zd, int sd);
      drain();
      write_csr(CSR_PULSE_MIN, PULSE_W'(pmin));
      write_csr(CSR_PULSE_MAX, PULSE_W'(pmax));
      write_csr(CSR_ACCEL, PULSE_W'(zd));
      write_csr(CSR_DEF_SPEED, PULSE_W'(sd));
   endtask

   task automatic run_until_still(int cap);
      int k;
      k = 0;
      while (any_moving() && k < cap) begin
         send(ACT_TICK, '0, '0, '0);
         k++;
      end
   endtask

   task automatic test_directed();
      send(ACT_TICK, 2'd0, '0, '0);                       // nothing moving
      send(ACT_SET, 2'd0, 24'h000000, 8'd0);
      send(ACT_SET, 2'd1, 24'hFFFFFF, 8'hFF);             // clamps to 180
      send(ACT_SPEED, 2'd2, 24'h5A0000, 8'd0);            // zero speed means one
      send(ACT_SPEED, 2'd3, 24'h5A0000, 8'hFF);
      send(ACT_MOVE, 2'd0, 24'h050000, 8'd1);
      send(ACT_MOVE, 2'd1, 24'h000000, 8'hFF);
      send(ACT_MOVE, 2'd2, 24'h5A3000, 8'd0);             // inside snap window
      send(ACT_MOVE, 2'd3, 24'h5C0000, 8'd0);
      send(ACT_UNUSED, 2'd0, 24'h100000, 8'd1);
      send(3'd6, 2'd1, 24'h100000, 8'd1);
      send(3'd7, 2'd2, 24'h100000, 8'd1);
      repeat (12) send(ACT_TICK, '0, '0, '0);
      send(ACT_SET, 2'd1, 24'h5A0000, 8'd0);
      run_until_still(400);
   endtask

   task automatic test_profiles();
      // ramp off, zero default speed, inverted pulse range
      set_profile(20000, 0, 0, 0);
      send(ACT_MOVE, 2'd0, 24'h0A0000, 8'd0);
      send(ACT_MOVE, 2'd1, 24'h000100, 8'd0);             // target below one degree
      run_until_still(60);
      set_profile(0, 32767, 180, 255);
      send(ACT_SET, 2'd2, 24'h000000, 8'd0);
      send(ACT_MOVE, 2'd2, 24'h040000, 8'd1);
      send(ACT_MOVE, 2'd3, 24'hFFFFFF, 8'd0);
      send(ACT_SET, 2'd3, 24'h5A0000, 8'd0);
      run_until_still(300);
      set_profile(500, 2400, 1, 1);
      send(ACT_MOVE, 2'd0, 24'h020000, 8'd2);
      run_until_still(300);
      set_profile(1000, 2000, 10, 3);
   endtask

   task automatic test_random(int count, bit quiet_tail);
      int r, made;
      made = 0;
      while (made < count) begin
         if (quiet_tail && made >= count - 20) gaps_on = 1'b0;
         r = $urandom_range(0, 99);
         if (r < 45) begin
            send(ACT_TICK, 2'($urandom), 24'($urandom), 8'($urandom));
         end else if (r < 70) begin
            logic [ANG_W-1:0] a;
            a = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                            : 24'($urandom_range(0, 180 * 65536));
            send(ACT_MOVE, 2'($urandom), a, 8'($urandom_range(0, 3) == 0 ?
                 $urandom : $urandom_range(0, 3)));
         end else if (r < 80) begin
            send(ACT_SET, 2'($urandom), 24'($urandom), 8'($urandom));
         end else if (r < 90) begin
            send(ACT_SPEED, 2'($urandom), 24'($urandom),
                 8'($urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom));
         end else if (r < 92) begin
            send(ACT_DISABLE, 2'($urandom), 24'($urandom), 8'($urandom));
         end else if (r < 95) begin
            send(3'($urandom_range(5, 7)), 2'($urandom), 24'($urandom), 8'($urandom));
            made--;
         end else begin
            // stalled channels far from goal: bring them in with a set
            send(ACT_SET, 2'($urandom), 24'($urandom_range(0, 180 * 65536)), 8'($urandom));
         end
         made++;
      end
   endtask

   initial begin
      pw_min = RST_PULSE_MIN;
      pw_max = RST_PULSE_MAX;
      zone_deg = RST_ACCEL;
      speed_dflt = RST_SPEED;
      for (int i = 0; i < NCH; i++) begin
         pos_now[i] = 64'd90 << FRAC_BITS;
         pos_goal[i] = 64'd90 << FRAC_BITS;
         span[i] = 0;
         rate[i] = RST_SPEED;
         moving[i] = 1'b0;
      end
      pwm_on = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_profiles();
      test_random(30, 1'b0);
      set_profile(500, 2400, 10, 10);
      test_random(40, 1'b1);
      drain();
      if (errors == 0 && expected_reports.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
